FILE: hdl/tachometer_period_to_rpm_top_macros.svh
// Assertion macros shared by the checker.
`ifndef TACHOMETER_PERIOD_TO_RPM_TOP_MACROS_SVH
`define TACHOMETER_PERIOD_TO_RPM_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define TPR_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define TPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also checks through reset.
`define TPR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/tpr_pkg.sv
package tpr_pkg;

    localparam int STAMP_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    // dividend is 2*ticks_per_minute + period, below 2^34
    localparam int NUM_W           = FIELD_W + 2;
    localparam logic [FIELD_W-1:0] TPM_RESET = 32'd60000000;

    localparam logic [1:0] MODE_ARM     = 2'd0;
    localparam logic [1:0] MODE_CAPTURE = 2'd1;
    localparam logic [1:0] MODE_DISARM  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } tpr_state_t;

    typedef struct packed {
        logic               done;
        logic [FIELD_W-1:0] quot;
    } tpr_div_status_t;

endpackage

FILE: hdl/tpr_div.sv
// Restoring divider, one quotient bit per cycle.
module tpr_div
    import tpr_pkg::*;
#(
    parameter int DEN_W = STAMP_WIDTH_DEF + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output tpr_div_status_t  status
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;
    logic           fits;

    always_comb begin
        shifted  = {rem_reg, num_reg[NUM_W-1]};
        diff     = shifted - {1'b0, den_reg};
        fits     = (shifted >= {1'b0, den_reg});
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            num_next = num;
            den_next = den;
            rem_next = '0;
            cnt_next = CNT_W'(NUM_W);
        end else if (cnt_reg != '0) begin
            // quotient bits shift in behind the dividend bits
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign status.done = done_reg;
    assign status.quot = num_reg[FIELD_W-1:0];

endmodule

FILE: hdl/tachometer_period_to_rpm_top.sv
// Single-shot fan tachometer: period between two captured edges, turned into rpm.
// Input channel (s_valid/s_ready): s_mode 0 arms a measurement and drops any
// stored first stamp, 1 is a capture with s_timestamp, 2 disarms, 3 is ignored.
// While armed, the first capture stores its stamp; the second capture gives one
// result item on the m_ channel and disarms. Captures while disarmed give nothing.
// Result: m_rpm = round-half-up(ticks_per_minute / period), m_period_ticks, and
// m_zero_period, set with rpm 0 when both stamps are equal.
// cfg_wr_en/cfg_wr_data write ticks_per_minute; write only while idle.
// A result-producing capture loads the restoring divider at the accepting edge;
// the divider shifts in one quotient bit each iteration, then the quotient is
// registered into m_rpm and m_valid rises; a zero period goes straight to the
// result. The block is not ready while dividing, so a measurement holds off
// the input until its quotient is registered.
// While a result waits on m_ready, items that give no result are still taken;
// a capture that would give a second result is held off until the first leaves.
// Reset (aresetn low, synchronous) disarms, clears the stored stamp flag, drops
// any pending result and restores ticks_per_minute to 60000000.
module tachometer_period_to_rpm_top
    import tpr_pkg::*;
#(
    parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [FIELD_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [FIELD_W-1:0] s_timestamp,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_rpm,
    output logic [FIELD_W-1:0] m_period_ticks,
    output logic               m_zero_period
);

    localparam int DEN_W = STAMP_WIDTH + 1;

    tpr_state_t state_reg, state_next;
    logic armed_reg, armed_next;
    logic have_first_reg, have_first_next;
    logic [STAMP_WIDTH-1:0] first_reg, first_next;
    logic [FIELD_W-1:0] tpm_reg, tpm_next;
    logic [FIELD_W-1:0] rpm_reg, rpm_next;
    logic [STAMP_WIDTH-1:0] per_reg, per_next;
    logic zero_reg, zero_next;

    logic [STAMP_WIDTH-1:0] stamp;
    logic [STAMP_WIDTH-1:0] period;
    logic                   is_final;
    logic                   s_fire;
    logic                   m_fire;
    logic                   div_start;
    logic [NUM_W-1:0]       div_num;
    logic [DEN_W-1:0]       div_den;
    tpr_div_status_t        div_status;

    assign stamp    = s_timestamp[STAMP_WIDTH-1:0];
    assign period   = stamp - first_reg;   // wraps modulo the stamp width
    assign is_final = (s_mode == MODE_CAPTURE) && armed_reg && have_first_reg;

    // idle takes anything; with a result pending, only items that add no result
    assign s_ready = (state_reg == ST_IDLE) || ((state_reg == ST_OUT) && !is_final);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (state_reg == ST_OUT);
    assign m_fire  = m_valid && m_ready;

    // (2*tpm + p) / (2*p) gives the half-up rounding
    assign div_num   = NUM_W'({tpm_reg, 1'b0}) + NUM_W'(per_next);
    assign div_den   = {per_next, 1'b0};
    assign div_start = s_fire && is_final && (period != '0);

    tpr_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .status  (div_status)
    );

    always_comb begin
        state_next      = state_reg;
        armed_next      = armed_reg;
        have_first_next = have_first_reg;
        first_next      = first_reg;
        tpm_next        = cfg_wr_en ? cfg_wr_data : tpm_reg;
        rpm_next        = rpm_reg;
        per_next        = per_reg;
        zero_next       = zero_reg;

        if (s_fire) begin
            case (s_mode)
                MODE_ARM: begin
                    armed_next      = 1'b1;
                    have_first_next = 1'b0;
                end
                MODE_DISARM: begin
                    armed_next      = 1'b0;
                    have_first_next = 1'b0;
                end
                MODE_CAPTURE: begin
                    if (armed_reg && !have_first_reg) begin
                        first_next      = stamp;
                        have_first_next = 1'b1;
                    end else if (is_final) begin
                        armed_next      = 1'b0;
                        have_first_next = 1'b0;
                        per_next        = period;
                        if (period == '0) begin
                            rpm_next  = '0;
                            zero_next = 1'b1;
                        end else begin
                            zero_next = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && is_final) begin
                    state_next = (period == '0) ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    rpm_next   = div_status.quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            armed_reg      <= 1'b0;
            have_first_reg <= 1'b0;
            tpm_reg        <= TPM_RESET;
        end else begin
            state_reg      <= state_next;
            armed_reg      <= armed_next;
            have_first_reg <= have_first_next;
            tpm_reg        <= tpm_next;
        end
        first_reg <= first_next;
        rpm_reg   <= rpm_next;
        per_reg   <= per_next;
        zero_reg  <= zero_next;
    end

    assign m_rpm          = rpm_reg;
    assign m_period_ticks = FIELD_W'(per_reg);
    assign m_zero_period  = zero_reg;

endmodule

FILE: hdl/tpr_checker.sv
`include "tachometer_period_to_rpm_top_macros.svh"

module tpr_checker
    import tpr_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [FIELD_W-1:0] m_rpm,
    input logic [FIELD_W-1:0] m_period_ticks,
    input logic               m_zero_period
);

    logic [2*FIELD_W:0] m_res;
    logic               m_nums_zero;

    assign m_res       = {m_rpm, m_period_ticks, m_zero_period};
    assign m_nums_zero = (m_rpm == '0) && (m_period_ticks == '0);

    // a stalled result holds its value
    `TPR_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_res))

    // reset drops any pending result
    `TPR_ASSERT_NEXT_ALWAYS(a_reset_clear, aclk, !aresetn, !m_valid)

    // equal stamps give all-zero numbers
    `TPR_ASSERT_IMPLY(a_zero_fields, aclk, aresetn, m_valid && m_zero_period, m_nums_zero)

    // a real period is never zero
    `TPR_ASSERT_IMPLY(a_period_nz, aclk, aresetn, m_valid && !m_zero_period, m_period_ticks != '0)

endmodule

bind tachometer_period_to_rpm_top tpr_checker u_tpr_checker (.*);
